// ----- rtl/isrt_pkg.sv -----
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared types and constants for the insertion sorter cell chain.
// ----------------------------------------------------------------------------
package isrt_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [COUNT_W-1:0]       count_t;

    typedef enum logic
    {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed
    {
        logic  insert;
        logic  shift;
        data_t sample;
    } cell_ctrl_t;

endpackage

// ----- rtl/isrt_cell.sv -----
// ----------------------------------------------------------------------------
// isrt_cell
// One entry of the sorted chain: compare, take the lower neighbor or the new
// sample on insert, take the upper neighbor on drain.
// ----------------------------------------------------------------------------
module isrt_cell
(
    input  logic                clk,
    input  isrt_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                prev_gt,
    input  isrt_pkg::data_t     prev_value,
    input  isrt_pkg::data_t     upper_value,
    output logic                gt,
    output isrt_pkg::data_t     value
);

    isrt_pkg::data_t value_reg;
    isrt_pkg::data_t value_next;

    assign gt    = occupied && (value_reg > ctrl.sample);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            // Larger entries move up; the sample lands at the first gap
            if (prev_gt)
                value_next = prev_value;
            else if (gt || !occupied)
                value_next = ctrl.sample;
        end
        else if (ctrl.shift)
        begin
            value_next = upper_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- rtl/insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter
// Systolic insertion sorter: a chain of CAPACITY cells keeps the set sorted.
// Throughput: one input transaction per cycle while collecting; each value
// is in place in the cycle after acceptance. After the final transaction,
// the state register and then the single output register in front of cell 0
// lie before the first result; the set of N values drains one result per
// cycle while the receiver is ready, input held off until the last is loaded.
// Reset: rst_n clears fill count, overflow flag, state and output valid;
// stored values are undefined until written.
// ----------------------------------------------------------------------------
module insertion_sorter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  sample_value,
    input  logic                final_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  sorted_value,
    output logic                end_of_set,
    output logic                dropped_flag
);

    localparam int CAP = isrt_pkg::CAPACITY;

    isrt_pkg::state_t   state_reg, state_next;
    isrt_pkg::count_t   fill_count_reg, fill_count_next;
    logic               overflow_reg, overflow_next;
    logic               out_valid_reg, out_valid_next;
    isrt_pkg::data_t    out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;
    logic               out_drop_reg, out_drop_next;

    isrt_pkg::cell_ctrl_t ctrl;
    isrt_pkg::data_t      cell_value [CAP];
    logic [CAP-1:0]       cell_gt;

    logic in_accept;
    logic store_full;
    logic load_out;

    assign in_ready   = (state_reg == isrt_pkg::ST_COLLECT);
    assign in_accept  = in_valid && in_ready;
    assign store_full = (fill_count_reg == isrt_pkg::COUNT_W'(CAP));

    // Output register is free when empty or being taken this cycle
    assign load_out = (state_reg == isrt_pkg::ST_DRAIN) && (!out_valid_reg || out_ready);

    assign ctrl.insert = in_accept && !store_full;
    assign ctrl.shift  = load_out;
    assign ctrl.sample = sample_value;

    // Cell chain: cell 0 holds the smallest value and feeds the output
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic            prev_gt;
        isrt_pkg::data_t prev_value;
        isrt_pkg::data_t upper_value;

        if (i == 0)
        begin : g_first
            assign prev_gt    = 1'b0;
            assign prev_value = cell_value[0];
        end
        else
        begin : g_rest
            assign prev_gt    = cell_gt[i-1];
            assign prev_value = cell_value[i-1];
        end

        if (i == CAP - 1)
        begin : g_top
            assign upper_value = cell_value[i];
        end
        else
        begin : g_mid
            assign upper_value = cell_value[i+1];
        end

        isrt_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (isrt_pkg::COUNT_W'(i) < fill_count_reg),
            .prev_gt     (prev_gt),
            .prev_value  (prev_value),
            .upper_value (upper_value),
            .gt          (cell_gt[i]),
            .value       (cell_value[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        overflow_next   = overflow_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_drop_next   = out_drop_reg;

        // Retire a result the consumer took
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            isrt_pkg::ST_COLLECT:
            begin
                if (in_accept)
                begin
                    // Insert, or drop and flag when the chain is full
                    if (store_full)
                        overflow_next = 1'b1;
                    else
                        fill_count_next = fill_count_reg + 1'b1;
                    if (final_item)
                        state_next = isrt_pkg::ST_DRAIN;
                end
            end
            isrt_pkg::ST_DRAIN:
            begin
                if (load_out)
                begin
                    // Advance cell 0 into the output register, shift chain down
                    out_valid_next  = 1'b1;
                    out_value_next  = cell_value[0];
                    out_last_next   = (fill_count_reg == isrt_pkg::COUNT_W'(1));
                    out_drop_next   = overflow_reg;
                    fill_count_next = fill_count_reg - 1'b1;
                    if (fill_count_reg == isrt_pkg::COUNT_W'(1))
                    begin
                        overflow_next = 1'b0;
                        state_next    = isrt_pkg::ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = isrt_pkg::ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= isrt_pkg::ST_COLLECT;
            fill_count_reg <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            overflow_reg   <= overflow_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload of the output register: no reset needed
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_drop_reg  <= out_drop_next;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign end_of_set   = out_last_reg;
    assign dropped_flag = out_drop_reg;

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the insertion sorter. Values are offered in sets,
// each closed by a transaction marked final. A behavioral copy of the sorted
// store predicts every emitted value in order, with its end and overflow
// marks. Random idle gaps on both sides, a long receiver hold-off and a full
// drain pause exercise the flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    // Bounds of the run: the cycle limit covers every set at full size with
    // the longest gaps on both sides, several times over.
    localparam int LIMIT_CYCLES = 400000;
    localparam int END_WAIT     = 20;
    localparam int HOLD_CYCLES  = 200;

    localparam isrt_pkg::data_t VAL_MAX = 32'sh7FFFFFFF;
    localparam isrt_pkg::data_t VAL_MIN = 32'sh80000000;

    // One emitted value with its marks
    typedef struct packed
    {
        isrt_pkg::data_t value;
        logic            last;
        logic            dropped;
    } sorted_result_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    isrt_pkg::data_t sample_value = '0;
    logic            final_item = 1'b0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    isrt_pkg::data_t sorted_value;
    logic            end_of_set;
    logic            dropped_flag;

    // Predictor state: the set collected so far, kept in ascending order
    isrt_pkg::data_t shadow_store[$];
    logic            shadow_overflow = 1'b0;
    sorted_result_t  expected_sorted[$];

    int fail_count  = 0;
    int cycle_count = 0;

    // Flow-control knobs shared between the tests and the receiver
    bit tx_gaps_on  = 1'b1;
    bit rx_gaps_on  = 1'b1;
    int rx_hold_req = 0;
    int hold_left   = 0;
    int rx_gap_left = 0;

    insertion_sorter i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .final_item   (final_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .end_of_set   (end_of_set),
        .dropped_flag (dropped_flag)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Gap length: mostly short, now and then a long one
    function automatic int draw_gap();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Value mix: extremes, a narrow band that forces ties, and full-range noise
    function automatic isrt_pkg::data_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
            1, 2, 3: return isrt_pkg::data_t'($urandom_range(0, 16)) - 8;
            default: return isrt_pkg::data_t'($urandom);
        endcase
    endfunction

    // Insert one accepted value into the shadow set; on final, queue the
    // whole set in ascending order and clear it.
    function automatic void predict_insertion(isrt_pkg::data_t v, logic last);
        int pos;
        if (shadow_store.size() >= isrt_pkg::CAPACITY)
            shadow_overflow = 1'b1;
        else
        begin
            // Stop below the first entry not greater: ties keep arrival order
            pos = shadow_store.size();
            while (pos > 0 && shadow_store[pos-1] > v)
                pos--;
            shadow_store.insert(pos, v);
        end
        if (last)
        begin
            foreach (shadow_store[k])
                expected_sorted.push_back('{shadow_store[k],
                                            k == shadow_store.size() - 1,
                                            shadow_overflow});
            shadow_store.delete();
            shadow_overflow = 1'b0;
        end
    endfunction

    // Track every input transaction in the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            predict_insertion(sample_value, final_item);
    end

    // Compare every output transaction with the oldest expectation
    always @(posedge clk)
    begin
        sorted_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sorted.size() == 0)
            begin
                $display("%0t ERROR unexpected result: value %0d last %0b dropped %0b",
                         $time, sorted_value, end_of_set, dropped_flag);
                fail_count++;
            end
            else
            begin
                exp_r = expected_sorted.pop_front();
                if (sorted_value !== exp_r.value)
                begin
                    $display("%0t ERROR sorted_value: expected %0d, actual %0d",
                             $time, exp_r.value, sorted_value);
                    fail_count++;
                end
                if (end_of_set !== exp_r.last)
                begin
                    $display("%0t ERROR end_of_set: expected %0b, actual %0b",
                             $time, exp_r.last, end_of_set);
                    fail_count++;
                end
                if (dropped_flag !== exp_r.dropped)
                begin
                    $display("%0t ERROR dropped_flag: expected %0b, actual %0b",
                             $time, exp_r.dropped, dropped_flag);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: honor a requested hold-off first, else stall at random
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (rx_hold_req > 0)
        begin
            out_ready   <= 1'b0;
            hold_left   <= rx_hold_req - 1;
            rx_hold_req  = 0;
        end
        else if (rx_gap_left > 0)
        begin
            out_ready   <= 1'b0;
            rx_gap_left <= rx_gap_left - 1;
        end
        else if (rx_gaps_on && $urandom_range(0, 99) < 20)
        begin
            out_ready   <= 1'b0;
            rx_gap_left <= draw_gap() - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one value and hold it until the handshake completes. Called at a
    // rising edge; returns at the edge where the transaction was taken.
    task automatic offer_sample(isrt_pkg::data_t v, logic last);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 99) < 25) ? draw_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= v;
        final_item   <= last;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_set(int len);
        for (int i = 0; i < len; i++)
            offer_sample(pick_value(), i == len - 1);
    endtask

    // Drop valid and wait until every queued result has come back; wait for a
    // clock edge first so the predictor has seen the last accepted transaction.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_sorted.size() != 0)
            @(posedge clk);
    endtask

    // Both extremes, zero, neighbors of zero and alternating bit patterns
    task automatic test_extremes();
        isrt_pkg::data_t vals[$];
        vals = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN + 1, VAL_MAX - 1,
                 32'sh55555555, 32'shAAAAAAAA};
        foreach (vals[i])
            offer_sample(vals[i], i == vals.size() - 1);
    endtask

    // A set of one value, then repeated values, then a descending run
    task automatic test_single_and_ties();
        isrt_pkg::data_t vals[$];
        offer_sample(-5, 1'b1);
        vals = '{7, 7, -3, 7, VAL_MIN, VAL_MIN};
        foreach (vals[i])
            offer_sample(vals[i], i == vals.size() - 1);
        for (int i = 5; i > 0; i--)
            offer_sample(isrt_pkg::data_t'(i * 1000), i == 1);
    endtask

    // Fill the store exactly, then overrun it so the final value is dropped
    // too, then check that a short set afterwards comes out unflagged.
    task automatic test_full_store();
        send_set(isrt_pkg::CAPACITY);
        send_set(isrt_pkg::CAPACITY + 6);
        send_set(3);
    endtask

    // Hold the receiver off while a set drains and a second one is offered
    // back to back: the drain stalls and the input must stall with it.
    task automatic test_backpressure();
        tx_gaps_on  = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        send_set(40);
        send_set(30);
        wait_drained();
        tx_gaps_on = 1'b1;
    endtask

    // Random sets, mostly short, some long, a few near or past capacity
    task automatic test_random_sets(int n_items);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 10);
            else if (r < 95)
                len = $urandom_range(11, 40);
            else
                len = $urandom_range(isrt_pkg::CAPACITY - 2, isrt_pkg::CAPACITY + 6);
            send_set(len);
            sent += len;
        end
    endtask

    initial
    begin
        // Hold reset, then release it on a rising edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_single_and_ties();
        test_full_store();
        test_backpressure();

        // Run a stretch with no idling on either side, then with gaps
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        test_random_sets(40);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        test_random_sets(100);

        wait_drained();
        repeat (END_WAIT) @(posedge clk);

        if (expected_sorted.size() != 0)
        begin
            $display("%0t ERROR %0d results never arrived", $time, expected_sorted.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
